FILE: rtl/stg_pkg.sv
// ----------------------------------------------------------------------------
// stg_pkg
// Shared widths, reset values, register indexes and the quarter-wave sine
// function for the sine tone generator.
// ----------------------------------------------------------------------------
package stg_pkg;

    localparam int unsigned RATE_DEF      = 44100;
    localparam int unsigned SINE_BITS_DEF = 12;

    localparam int IDX_W    = 16;
    localparam int CFG_W    = 15;
    localparam int MAG_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CFG_W-1:0] TONE_FREQ_RST = 15'd262;
    localparam logic [CFG_W-1:0] AMPLITUDE_RST = 15'd30000;

    // register index, taken from paddr[2]
    localparam logic REG_TONE_FREQ = 1'b0;
    localparam logic REG_AMPLITUDE = 1'b1;

    localparam longint HALF_PI_Q30 = 64'd1686629713;

    // Magnitude of the sine at m/Q of a quarter turn, Q1.15, by a Taylor
    // series on a Q2.30 angle. Evaluated at elaboration only.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned m,
                                                      input int unsigned sine_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          sum;
        longint          r;
        x   = (longint'(m) * HALF_PI_Q30) >> (sine_bits - 2);
        x2  = (x * x) >> 30;
        t   = x;
        sum = longint'(x);
        t   = ((t * x2) >> 30) / 6;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 20;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 42;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 72;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 110;
        sum = sum - longint'(t);
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end
        return r[MAG_W-1:0];
    endfunction

endpackage

FILE: rtl/stg_phase.sv
// ----------------------------------------------------------------------------
// stg_phase
// Four-stage phase unit: index times frequency, then the product reduced
// modulo RATE by a reciprocal multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module stg_phase #(
    parameter int unsigned RATE = stg_pkg::RATE_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [stg_pkg::IDX_W-1:0]   sample_index,
    input  logic [stg_pkg::CFG_W-1:0]   tone_freq,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [$clog2(RATE)-1:0]     phase
);
    import stg_pkg::*;

    localparam int PROD_W = IDX_W + CFG_W;
    localparam int P_W    = $clog2(RATE);
    localparam longint unsigned RECIP = (64'd1 << PROD_W) / RATE;
    localparam int R_W    = $clog2(RECIP + 1);
    localparam logic [R_W-1:0] RECIP_C = R_W'(RECIP);
    localparam logic [P_W:0]   RATE_X  = (P_W + 1)'(RATE);

    logic [3:0]              v_reg;
    logic [3:0]              adv;
    logic [PROD_W-1:0]       prod_reg;
    logic [PROD_W-1:0]       prod1_reg;
    logic [PROD_W-1:0]       prod2_reg;
    logic [R_W-1:0]          qe_reg;
    logic [PROD_W-1:0]       qm_reg;
    logic [P_W-1:0]          phase_reg;
    logic [PROD_W+R_W-1:0]   qe_full;
    logic [PROD_W-1:0]       qm_full;
    logic [PROD_W-1:0]       diff;
    logic [P_W:0]            r0;
    logic [P_W:0]            r1;

    // a stage loads when empty or when the one after it moves on
    assign adv[3] = !v_reg[3] || out_ready;
    assign adv[2] = !v_reg[2] || adv[3];
    assign adv[1] = !v_reg[1] || adv[2];
    assign adv[0] = !v_reg[0] || adv[1];

    assign qe_full = PROD_W'(prod_reg) * (PROD_W + R_W)'(RECIP_C);
    assign qm_full = PROD_W'(qe_reg) * PROD_W'(RATE_X);
    // quotient estimate is low by at most one, so diff is below 2*RATE
    assign diff    = prod2_reg - qm_reg;
    assign r0      = diff[P_W:0];
    assign r1      = (r0 >= RATE_X) ? (r0 - RATE_X) : r0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            prod_reg <= PROD_W'(sample_index) * PROD_W'(tone_freq);
        end
        if (adv[1]) begin
            qe_reg    <= qe_full[PROD_W +: R_W];
            prod1_reg <= prod_reg;
        end
        if (adv[2]) begin
            qm_reg    <= qm_full;
            prod2_reg <= prod1_reg;
        end
        if (adv[3]) begin
            phase_reg <= r1[P_W-1:0];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[3];
    assign phase     = phase_reg;

endmodule

FILE: rtl/stg_index.sv
// ----------------------------------------------------------------------------
// stg_index
// Three-stage scaling of the phase to a table index by a reciprocal multiply
// with one correcting step, then quadrant folding to a quarter-wave address.
// ----------------------------------------------------------------------------
module stg_index #(
    parameter int unsigned RATE      = stg_pkg::RATE_DEF,
    parameter int unsigned SINE_BITS = stg_pkg::SINE_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [$clog2(RATE)-1:0]   phase,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [SINE_BITS-2:0]      quarter_addr,
    output logic                      negate
);
    import stg_pkg::*;

    localparam int P_W = $clog2(RATE);
    localparam int N_W = P_W + SINE_BITS;
    localparam longint unsigned RECIP = (64'd1 << N_W) / RATE;
    localparam int R_W = $clog2(RECIP + 1);
    localparam logic [R_W-1:0] RECIP_C = R_W'(RECIP);
    localparam logic [N_W-1:0] RATE_N  = N_W'(RATE);
    localparam logic [SINE_BITS-2:0] QUARTER = (SINE_BITS - 1)'(1) << (SINE_BITS - 2);

    logic [2:0]             v_reg;
    logic [2:0]             adv;
    logic [SINE_BITS-1:0]   ke_reg;
    logic [SINE_BITS-1:0]   ke1_reg;
    logic [P_W-1:0]         p0_reg;
    logic [P_W-1:0]         p1_reg;
    logic [N_W-1:0]         km_reg;
    logic [SINE_BITS-2:0]   addr_reg;
    logic                   neg_reg;
    logic [P_W+R_W-1:0]     ke_full;
    logic [N_W-1:0]         num;
    logic [N_W-1:0]         rem;
    logic [SINE_BITS-1:0]   k;
    logic [1:0]             quad;
    logic [SINE_BITS-2:0]   offs;
    logic [SINE_BITS-2:0]   addr;

    assign adv[2] = !v_reg[2] || out_ready;
    assign adv[1] = !v_reg[1] || adv[2];
    assign adv[0] = !v_reg[0] || adv[1];

    assign ke_full = (P_W + R_W)'(phase) * (P_W + R_W)'(RECIP_C);
    assign num     = {p1_reg, {SINE_BITS{1'b0}}};
    assign rem     = num - km_reg;
    // estimate is low by at most one
    assign k       = (rem >= RATE_N) ? (ke1_reg + 1'b1) : ke1_reg;
    assign quad    = k[SINE_BITS-1 -: 2];
    assign offs    = {1'b0, k[SINE_BITS-3:0]};
    // mirror odd quadrants
    assign addr    = quad[0] ? (QUARTER - offs) : offs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            ke_reg <= ke_full[P_W +: SINE_BITS];
            p0_reg <= phase;
        end
        if (adv[1]) begin
            km_reg  <= N_W'(ke_reg) * RATE_N;
            ke1_reg <= ke_reg;
            p1_reg  <= p0_reg;
        end
        if (adv[2]) begin
            addr_reg <= addr;
            neg_reg  <= quad[1];
        end
    end

    assign in_ready     = adv[0];
    assign out_valid    = v_reg[2];
    assign quarter_addr = addr_reg;
    assign negate       = neg_reg;

endmodule

FILE: rtl/stg_rom.sv
// ----------------------------------------------------------------------------
// stg_rom
// Quarter-wave sine magnitude table, Q1.15, with a registered read.
// ----------------------------------------------------------------------------
module stg_rom #(
    parameter int unsigned SINE_BITS = stg_pkg::SINE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [SINE_BITS-2:0]        quarter_addr,
    input  logic                        negate_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [stg_pkg::MAG_W-1:0]   mag,
    output logic                        negate_out
);
    import stg_pkg::*;

    localparam int DEPTH = (1 << (SINE_BITS - 2)) + 1;

    logic [MAG_W-1:0] rom [DEPTH];
    logic             v_reg;
    logic             adv;
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;

    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        assign rom[g] = quarter_sine(g, SINE_BITS);
    end

    assign adv = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg <= rom[quarter_addr];
            neg_reg <= negate_in;
        end
    end

    assign in_ready   = adv;
    assign out_valid  = v_reg;
    assign mag        = mag_reg;
    assign negate_out = neg_reg;

endmodule

FILE: rtl/stg_scale.sv
// ----------------------------------------------------------------------------
// stg_scale
// Two-stage amplitude scaling: Q15 product truncated, then sign applied into
// the output register.
// ----------------------------------------------------------------------------
module stg_scale (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [stg_pkg::MAG_W-1:0]           mag,
    input  logic                                negate,
    input  logic [stg_pkg::CFG_W-1:0]           amplitude,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [stg_pkg::SAMPLE_W-1:0] sample
);
    import stg_pkg::*;

    localparam int PROD_W = CFG_W + MAG_W;

    logic [1:0]                  v_reg;
    logic [1:0]                  adv;
    logic [PROD_W-1:0]           prod_full;
    logic [MAG_W-1:0]            prod_reg;
    logic                        neg_reg;
    logic signed [SAMPLE_W-1:0]  sample_reg;
    logic signed [SAMPLE_W-1:0]  pos;

    assign adv[1] = !v_reg[1] || out_ready;
    assign adv[0] = !v_reg[0] || adv[1];

    assign prod_full = PROD_W'(amplitude) * PROD_W'(mag);
    assign pos       = signed'({1'b0, prod_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            prod_reg <= prod_full[PROD_W-1 -: MAG_W];
            neg_reg  <= negate;
        end
        if (adv[1]) begin
            sample_reg <= neg_reg ? -pos : pos;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[1];
    assign sample    = sample_reg;

endmodule

FILE: rtl/sine_tone_generator.sv
// ----------------------------------------------------------------------------
// sine_tone_generator
// Direct digital synthesis of one signed 16-bit sine sample per sample index.
//
//   channel  direction  ports                           payload
//   s_       in         s_valid / s_ready               s_sample_index [15:0]
//   m_       out        m_valid / m_ready               m_sample [15:0] signed
//   config   APB        psel penable pwrite paddr ...   tone_freq, amplitude
//
// One item per clock unless m_ready stalls the full pipe; stages from acceptance
// to m_valid: phase 4, index 3, table read 1, scaling 2.
// Reset sets tone_freq to 262 and amplitude to 30000 and empties every stage.
// Each stage holds while the next stage is full and not moving; empty stages
// keep filling while a result waits on m_ready, so nothing is lost or doubled.
// ----------------------------------------------------------------------------
module sine_tone_generator #(
    parameter int unsigned RATE      = stg_pkg::RATE_DEF,
    parameter int unsigned SINE_BITS = stg_pkg::SINE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [stg_pkg::IDX_W-1:0]           s_sample_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [stg_pkg::SAMPLE_W-1:0] m_sample,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stg_pkg::APB_AW-1:0]          paddr,
    input  logic [stg_pkg::APB_DW-1:0]          pwdata,
    output logic [stg_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);
    import stg_pkg::*;

    localparam int P_W = $clog2(RATE);

    logic [CFG_W-1:0]     tone_freq_reg;
    logic [CFG_W-1:0]     amplitude_reg;
    logic                 cfg_wr;
    logic                 reg_sel;

    logic                 ph_valid;
    logic                 ph_ready;
    logic [P_W-1:0]       phase;
    logic                 ix_valid;
    logic                 ix_ready;
    logic [SINE_BITS-2:0] quarter_addr;
    logic                 ix_negate;
    logic                 rom_valid;
    logic                 rom_ready;
    logic [MAG_W-1:0]     mag;
    logic                 rom_negate;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_freq_reg <= TONE_FREQ_RST;
            amplitude_reg <= AMPLITUDE_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_TONE_FREQ: tone_freq_reg <= pwdata[CFG_W-1:0];
                REG_AMPLITUDE: amplitude_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_TONE_FREQ: prdata = APB_DW'(tone_freq_reg);
            REG_AMPLITUDE: prdata = APB_DW'(amplitude_reg);
            default:       prdata = '0;
        endcase
    end

    stg_phase #(
        .RATE (RATE)
    ) u_phase (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .sample_index (s_sample_index),
        .tone_freq    (tone_freq_reg),
        .out_valid    (ph_valid),
        .out_ready    (ph_ready),
        .phase        (phase)
    );

    stg_index #(
        .RATE      (RATE),
        .SINE_BITS (SINE_BITS)
    ) u_index (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (ph_valid),
        .in_ready     (ph_ready),
        .phase        (phase),
        .out_valid    (ix_valid),
        .out_ready    (ix_ready),
        .quarter_addr (quarter_addr),
        .negate       (ix_negate)
    );

    stg_rom #(
        .SINE_BITS (SINE_BITS)
    ) u_rom (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (ix_valid),
        .in_ready     (ix_ready),
        .quarter_addr (quarter_addr),
        .negate_in    (ix_negate),
        .out_valid    (rom_valid),
        .out_ready    (rom_ready),
        .mag          (mag),
        .negate_out   (rom_negate)
    );

    stg_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rom_valid),
        .in_ready  (rom_ready),
        .mag       (mag),
        .negate    (rom_negate),
        .amplitude (amplitude_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .sample    (m_sample)
    );

    // input backs up only when the whole pipe is full behind a stalled output
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without an output stall");

    // magnitude never exceeds 32767, so the most negative code never appears
    a_no_min_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample != 16'sh8000))
        else $error("sample reached the most negative code");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sine_tone_generator. A directed table covers the
// register extremes, zero frequency, zero amplitude, aliasing frequencies and
// indexes past the sample rate. A long random run follows under three
// back-pressure profiles. Every sample is checked against its table value or
// a local bit-accurate DDS model. Register writes are read back over APB.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stg_pkg::*;

    localparam longint unsigned HALF_PI_FX  = 64'd1686629713;
    localparam longint unsigned RATE_HZ     = RATE_DEF;
    localparam int unsigned     TABLE_BITS  = SINE_BITS_DEF;
    localparam longint unsigned QUARTER_LEN = 64'd1 << (TABLE_BITS - 2);
    localparam int              CYCLE_LIMIT = 200000;
    localparam int              SEGMENTS    = 4;
    localparam int              SEG_ITEMS   = 130;

    localparam logic [APB_AW-1:0] ADDR_TONE_FREQ = {REG_TONE_FREQ, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_AMPLITUDE = {REG_AMPLITUDE, 2'b00};

    typedef enum logic [1:0] {
        ROW_SET_FREQ,
        ROW_SET_AMP,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [31:0]        value;
        bit                 checked;
        logic signed [15:0] want;
    } stim_row_t;

    localparam int N_ROWS = 30;

    // after reset: 262 Hz at amplitude 30000
    stim_row_t directed_rows [N_ROWS] = '{
        '{ROW_SAMPLE,   32'd0,         1'b1, 16'sd0},
        '{ROW_SAMPLE,   32'd44099,     1'b0, 16'sd0},
        '{ROW_SAMPLE,   32'd65535,     1'b0, 16'sd0},
        '{ROW_SAMPLE,   32'd1,         1'b0, 16'sd0},
        '{ROW_SET_FREQ, 32'd0,         1'b0, 16'sd0},
        '{ROW_SAMPLE,   32'd12345,     1'b1, 16'sd0},
        '{ROW_SAMPLE,   32'd65535,     1'b1, 16'sd0},
        '{ROW_SET_FREQ, 32'd11025,     1'b0, 16'sd0},
        '{ROW_SET_AMP,  32'd32767,     1'b0, 16'sd0},
        '{ROW_SAMPLE,   32'd1,         1'b1, 16'sd32766},
        '{ROW_SAMPLE,   32'd2,         1'b1, 16'sd0},
        '{ROW_SAMPLE,   32'd3,         1'b1, -16'sd32766},
        '{ROW_SAMPLE,   32'd44101,     1'b1, 16'sd32766},
        '{ROW_SAMPLE,   32'd5,         1'b1, 16'sd32766},
        '{ROW_SAMPLE,   32'd7,         1'b1, -16'sd32766},
        '{ROW_SET_AMP,  32'd0,         1'b0, 16'sd0},
        '{ROW_SAMPLE,   32'd1,         1'b1, 16'sd0},
        '{ROW_SAMPLE,   32'd3,         1'b1, 16'sd0},
        '{ROW_SET_FREQ, 32'hFFFF_FFFF, 1'b0, 16'sd0},
        '{ROW_SET_AMP,  32'hFFFF_8001, 1'b0, 16'sd0},
        '{ROW_SAMPLE,   32'd65535,     1'b0, 16'sd0},
        '{ROW_SAMPLE,   32'd1,         1'b0, 16'sd0},
        '{ROW_SET_AMP,  32'd32767,     1'b0, 16'sd0},
        '{ROW_SAMPLE,   32'd44099,     1'b0, 16'sd0},
        '{ROW_SAMPLE,   32'd32768,     1'b0, 16'sd0},
        '{ROW_SET_FREQ, 32'd22050,     1'b0, 16'sd0},
        '{ROW_SAMPLE,   32'd1,         1'b1, 16'sd0},
        '{ROW_SET_FREQ, 32'h0001_8001, 1'b0, 16'sd0},
        '{ROW_SAMPLE,   32'd11025,     1'b1, 16'sd32766},
        '{ROW_SAMPLE,   32'd33075,     1'b1, -16'sd32766}
    };

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic [IDX_W-1:0]           s_sample_index = '0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample;
    logic                       psel           = 1'b0;
    logic                       penable        = 1'b0;
    logic                       pwrite         = 1'b0;
    logic [APB_AW-1:0]          paddr          = '0;
    logic [APB_DW-1:0]          pwdata         = '0;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic [CFG_W-1:0]           freq_hz;
    logic [CFG_W-1:0]           peak_amp;
    int                         mismatches     = 0;
    int                         cycle_count    = 0;
    int                         send_idle_pct  = 0;
    int                         recv_idle_pct  = 0;

    sine_tone_generator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_index (s_sample_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Q1.15 sine magnitude at m/QUARTER_LEN of a quarter turn, Taylor series in Q2.30
    function automatic logic [MAG_W-1:0] quarter_wave_mag(input longint unsigned m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned divisor;
        longint          acc;
        longint          rounded;
        x   = (m * HALF_PI_FX) >> (TABLE_BITS - 2);
        x2  = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 5; n++) begin
            divisor = longint'(2 * n) * longint'(2 * n + 1);
            term = ((term * x2) >> 30) / divisor;
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        rounded = (acc + 16384) / 32768;
        if (rounded > 32767) begin
            rounded = 32767;
        end
        return rounded[MAG_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] synth_sample(input logic [IDX_W-1:0] idx);
        longint unsigned phase;
        longint unsigned k;
        longint unsigned quad;
        longint unsigned off;
        longint unsigned m;
        longint unsigned prod;
        longint unsigned signed_prod;
        phase = (longint'(idx) * longint'(freq_hz)) % RATE_HZ;
        k     = (phase << TABLE_BITS) / RATE_HZ;
        quad  = (k >> (TABLE_BITS - 2)) & 64'd3;
        off   = k & (QUARTER_LEN - 1);
        m     = quad[0] ? (QUARTER_LEN - off) : off;
        prod  = (longint'(peak_amp) * longint'(quarter_wave_mag(m))) >> 15;
        signed_prod = quad[1] ? (64'd0 - prod) : prod;
        return signed_prod[SAMPLE_W-1:0];
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch: %s expected %0d got %0d (cycle %0d)", what, want, got,
                     cycle_count);
        end
    endtask

    // result side: random back-pressure and compare against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    note_mismatch("unexpected sample", 0, m_sample);
                end else if (m_sample !== expected_samples[0]) begin
                    note_mismatch("sample", expected_samples[0], m_sample);
                    void'(expected_samples.pop_front());
                end else begin
                    void'(expected_samples.pop_front());
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // call in the step where the previous item was accepted, or with the line idle
    task automatic send_index(input logic [IDX_W-1:0] idx, input bit checked,
                              input logic signed [SAMPLE_W-1:0] want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_index <= idx;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        expected_samples.push_back(checked ? want : synth_sample(idx));
    endtask

    // hold the input until every pending sample has come out
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (expected_samples.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic apb_read_check(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (pready !== 1'b1 || prdata !== {{(APB_DW - CFG_W){1'b0}}, want}) begin
            note_mismatch("register read", want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        // leave the bus idle before the next transfer
        @(posedge aclk);
    endtask

    task automatic write_register(input logic [APB_AW-1:0] addr, input logic [31:0] word);
        drain_pipeline();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TONE_FREQ) begin
            freq_hz = word[CFG_W-1:0];
        end else begin
            peak_amp = word[CFG_W-1:0];
        end
        @(posedge aclk);
        apb_read_check(addr, word[CFG_W-1:0]);
    endtask

    function automatic logic [31:0] random_freq_word();
        logic [31:0] word;
        int          pick;
        word = $urandom();
        pick = $urandom_range(9);
        if (pick == 0) begin
            word[CFG_W-1:0] = 15'd0;
        end else if (pick <= 2) begin
            word[CFG_W-1:0] = CFG_W'($urandom_range(32767, 22051));
        end else begin
            word[CFG_W-1:0] = CFG_W'($urandom_range(22050, 1));
        end
        return word;
    endfunction

    initial begin
        logic [IDX_W-1:0] base;
        bit               sequential;
        logic [IDX_W-1:0] idx;

        freq_hz  = TONE_FREQ_RST;
        peak_amp = AMPLITUDE_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apb_read_check(ADDR_TONE_FREQ, TONE_FREQ_RST);
        @(posedge aclk);
        apb_read_check(ADDR_AMPLITUDE, AMPLITUDE_RST);

        send_idle_pct = 6;
        recv_idle_pct = 51;
        for (int r = 0; r < N_ROWS; r++) begin
            case (directed_rows[r].kind)
                ROW_SET_FREQ: begin
                    write_register(ADDR_TONE_FREQ, directed_rows[r].value);
                end
                ROW_SET_AMP: begin
                    write_register(ADDR_AMPLITUDE, directed_rows[r].value);
                end
                default: begin
                    send_index(directed_rows[r].value[IDX_W-1:0], directed_rows[r].checked,
                               directed_rows[r].want);
                end
            endcase
        end

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 0) begin
                send_idle_pct = 6;
                recv_idle_pct = 51;
            end else if (phase == 1) begin
                send_idle_pct = 51;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                write_register(ADDR_TONE_FREQ, random_freq_word());
                if ($urandom_range(7) == 0) begin
                    write_register(ADDR_AMPLITUDE, {$urandom_range(1) ? 17'h1FFFF : 17'h0,
                                   $urandom_range(1) ? 15'd32767 : 15'd0});
                end else begin
                    write_register(ADDR_AMPLITUDE, $urandom());
                end
                // streaming segments walk consecutive indexes, like real audio
                sequential = $urandom_range(1);
                base       = IDX_W'($urandom_range(44099));
                for (int i = 0; i < SEG_ITEMS; i++) begin
                    if (sequential) begin
                        idx = IDX_W'((int'(base) + i) % 44100);
                    end else if ($urandom_range(99) < 85) begin
                        idx = IDX_W'($urandom_range(44099));
                    end else begin
                        idx = IDX_W'($urandom_range(65535, 44100));
                    end
                    send_index(idx, 1'b0, '0);
                end
            end
        end

        drain_pipeline();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
